/* src/inverse_cdf_sampler_top_defines.svh */
// Assertion macros shared by the inverse CDF sampler RTL.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef INVERSE_CDF_SAMPLER_TOP_DEFINES_SVH
`define INVERSE_CDF_SAMPLER_TOP_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define ICS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ICS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/ics_pkg.sv */
// Shared constants and controller/datapath interface types for the sampler.
// Depends on nothing.
package ics_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int FRACTION_BITS = 16;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int POS_W         = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W         = FRACTION_BITS + 1;
    localparam int LEN_W         = 9;

    localparam logic [VAL_W-1:0] ONE_VALUE   = VAL_W'(1) << FRACTION_BITS;
    localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(256);
    localparam logic [POS_W-1:0] DEPTH_COUNT = POS_W'(TABLE_DEPTH);

    typedef struct packed {
        logic load;    // store one probability entry this cycle
        logic init;    // begin a search this cycle
        logic search;  // one search step this cycle
    } ics_cmd_t;

    typedef struct packed {
        logic done;    // search interval is empty after this step
    } ics_status_t;

endpackage

/* src/ics_datapath.sv */
// Datapath: running sum, cumulative table memory and binary-search registers.
// Depends on ics_pkg.
module ics_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ics_pkg::ics_cmd_t                   cmd,
    output ics_pkg::ics_status_t                status,
    input  logic                                restart,
    input  logic [ics_pkg::VAL_W-1:0]           prob_entry,
    input  logic [ics_pkg::FRACTION_BITS-1:0]   uniform_draw,
    input  logic                                cfg_write,
    input  logic [ics_pkg::LEN_W-1:0]           cfg_data,
    output logic [ics_pkg::ADDR_W-1:0]          sampled_index
);

    logic [ics_pkg::VAL_W-1:0]         mem [ics_pkg::TABLE_DEPTH];
    logic [ics_pkg::VAL_W-1:0]         rd_data_reg;

    logic [ics_pkg::VAL_W-1:0]         sum_reg, sum_next, sum_base;
    logic [ics_pkg::VAL_W:0]           sum_wide;
    logic [ics_pkg::POS_W-1:0]         pos_reg, pos_next, pos_base;
    logic [ics_pkg::LEN_W-1:0]         len_reg, len_clamp;
    logic [ics_pkg::POS_W-1:0]         count_comb;
    logic [ics_pkg::POS_W-1:0]         n_reg;
    logic [ics_pkg::FRACTION_BITS-1:0] draw_reg;
    logic [ics_pkg::POS_W-1:0]         lo_reg, hi_reg, mid_reg;
    logic [ics_pkg::POS_W-1:0]         lo_upd, hi_upd, mid_next;
    logic [ics_pkg::POS_W:0]           mid_sum;
    logic                              pending_reg;
    logic                              greater;
    logic                              issue;
    logic                              mem_we;
    logic [ics_pkg::ADDR_W-1:0]        idx_next;
    logic [ics_pkg::ADDR_W-1:0]        idx_reg;

    // Load path: saturating running sum and write position.
    always_comb
    begin
        sum_base = restart ? '0 : sum_reg;
        pos_base = restart ? '0 : pos_reg;
        sum_wide = {1'b0, sum_base} + {1'b0, prob_entry};
        if (sum_wide > {1'b0, ics_pkg::ONE_VALUE})
            sum_next = ics_pkg::ONE_VALUE;
        else
            sum_next = sum_wide[ics_pkg::VAL_W-1:0];
        mem_we   = cmd.load && (pos_base < ics_pkg::DEPTH_COUNT);
        pos_next = mem_we ? pos_base + 1'b1 : pos_base;
    end

    // Searchable count: table length clamped to 1..depth, then to the fill.
    always_comb
    begin
        if (len_reg == '0)
            len_clamp = ics_pkg::LEN_W'(1);
        else if (len_reg > ics_pkg::LEN_W'(ics_pkg::TABLE_DEPTH))
            len_clamp = ics_pkg::LEN_W'(ics_pkg::TABLE_DEPTH);
        else
            len_clamp = len_reg;
        if (ics_pkg::POS_W'(len_clamp) > pos_reg)
            count_comb = pos_reg;
        else
            count_comb = ics_pkg::POS_W'(len_clamp);
    end

    // One probe per cycle: compare the entry read last cycle, narrow the
    // interval, and issue the read for the next midpoint.
    always_comb
    begin
        greater = rd_data_reg > {1'b0, draw_reg};
        if (cmd.init)
        begin
            lo_upd = '0;
            hi_upd = count_comb;
        end
        else if (pending_reg)
        begin
            lo_upd = greater ? lo_reg : mid_reg + 1'b1;
            hi_upd = greater ? mid_reg : hi_reg;
        end
        else
        begin
            lo_upd = lo_reg;
            hi_upd = hi_reg;
        end
        mid_sum  = {1'b0, lo_upd} + {1'b0, hi_upd};
        mid_next = mid_sum[ics_pkg::POS_W:1];
        issue    = (cmd.init || cmd.search) && (lo_upd < hi_upd);
        status.done = lo_upd >= hi_upd;
        if (n_reg == '0)
            idx_next = '0;
        else if (lo_upd >= n_reg)
            idx_next = ics_pkg::ADDR_W'(n_reg - 1'b1);
        else
            idx_next = ics_pkg::ADDR_W'(lo_upd);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[pos_base[ics_pkg::ADDR_W-1:0]] <= sum_next;
        if (issue)
            rd_data_reg <= mem[mid_next[ics_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            pos_reg     <= '0;
            len_reg     <= ics_pkg::LEN_RESET;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                sum_reg <= sum_next;
                pos_reg <= pos_next;
            end
            if (cfg_write)
                len_reg <= cfg_data;
            pending_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            n_reg    <= count_comb;
            draw_reg <= uniform_draw;
        end
        if (cmd.init || cmd.search)
        begin
            lo_reg  <= lo_upd;
            hi_reg  <= hi_upd;
            mid_reg <= mid_next;
        end
        if (cmd.search && status.done)
            idx_reg <= idx_next;
    end

    assign sampled_index = idx_reg;

endmodule

/* src/ics_ctrl.sv */
// Controller: accepts words, sequences the search and drives the result strobe.
// Depends on ics_pkg and inverse_cdf_sampler_top_defines.svh.
`include "inverse_cdf_sampler_top_defines.svh"

module ics_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 mode,
    input  ics_pkg::ics_status_t status,
    output ics_pkg::ics_cmd_t    cmd,
    output logic                 busy,
    output logic                 result_valid
);

    typedef enum logic {
        IDLE,
        SEARCH
    } state_t;

    state_t state_reg, state_next;
    logic   strobe_reg, strobe_next;
    logic   accept;

    always_comb
    begin
        accept      = start && (state_reg == IDLE);
        cmd.load    = accept && !mode;
        cmd.init    = accept && mode;
        cmd.search  = state_reg == SEARCH;
        state_next  = state_reg;
        strobe_next = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (cmd.init)
                    state_next = SEARCH;
            end
            SEARCH:
            begin
                if (status.done)
                begin
                    state_next  = IDLE;
                    strobe_next = 1'b1;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy         = state_reg == SEARCH;
    assign result_valid = strobe_reg;

    `ICS_ASSERT(a_strobe_after_search, strobe_reg |-> $past(state_reg == SEARCH), "result strobe without search")
    `ICS_ASSERT(a_init_enters_search, cmd.init |=> (state_reg == SEARCH), "sample did not start search")
    `ICS_ASSERT(a_load_no_result, cmd.load |=> !strobe_reg, "load produced a result")
    `ICS_ASSERT_ALWAYS(a_no_reset_strobe, !rst_n |-> !strobe_reg, "strobe during reset")

endmodule

/* src/inverse_cdf_sampler_top.sv */
// A load word is taken while the block is idle and busy stays low; a sample word
// reads one table entry per search step and, when the search interval is empty,
// registers the result strobe. The next word is taken at the edge that ends the
// strobe cycle. Reset (rst_n, asynchronous, active low) clears the running sum and
// the fill position and sets the length register to 256. The receiver cannot
// stall results.
//
// Top level of the inverse CDF sampler. Depends on ics_pkg, ics_ctrl and
// ics_datapath.
module inverse_cdf_sampler_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic                                restart,
    input  logic [ics_pkg::VAL_W-1:0]           prob_entry,
    input  logic [ics_pkg::FRACTION_BITS-1:0]   uniform_draw,
    output logic                                result_valid,
    output logic [ics_pkg::ADDR_W-1:0]          sampled_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ics_pkg::LEN_W-1:0]           cfg_data
);

    // The controller decides when a word is taken and steps the search; the
    // datapath holds the running sum, the cumulative table and the search
    // interval. They talk only through the command and status structs.
    ics_pkg::ics_cmd_t    cmd;
    ics_pkg::ics_status_t status;

    // The length register can always take a write; the user is to write it only while
    // the block is idle, which the block does not enforce, so no search ever sees it change.
    assign cfg_ready = 1'b1;

    ics_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    ics_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .restart       (restart),
        .prob_entry    (prob_entry),
        .uniform_draw  (uniform_draw),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .sampled_index (sampled_index)
    );

endmodule

/* dv/inverse_cdf_sampler_top_tb.sv */
// Self-checking testbench for inverse_cdf_sampler_top: loads cumulative tables, draws samples
// and compares every strobed index with a predictor kept inside the bench.
// Depends on ics_pkg and the sampler RTL only.
module inverse_cdf_sampler_top_tb;

    localparam int TABLE_DEPTH   = ics_pkg::TABLE_DEPTH;
    localparam int FRACTION_BITS = ics_pkg::FRACTION_BITS;
    localparam int ADDR_W        = ics_pkg::ADDR_W;
    localparam int POS_W         = ics_pkg::POS_W;
    localparam int VAL_W         = ics_pkg::VAL_W;
    localparam int LEN_W         = ics_pkg::LEN_W;

    localparam logic [VAL_W-1:0] ONE_VALUE   = ics_pkg::ONE_VALUE;
    localparam logic [LEN_W-1:0] LEN_RESET   = ics_pkg::LEN_RESET;
    localparam logic [POS_W-1:0] DEPTH_COUNT = ics_pkg::DEPTH_COUNT;

    // Number of words the random part aims for; the directed and sweep parts add about 550.
    localparam int WORD_GOAL     = 1200;
    // Cycles allowed after the last expected result before the block counts as idle.
    localparam int SETTLE_CYCLES = 12;
    // Hard stop for the whole run, far above the slowest correct run.
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int MAX_PRINTS    = 100;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     mode;
    logic                     restart;
    logic [VAL_W-1:0]         prob_entry;
    logic [FRACTION_BITS-1:0] uniform_draw;
    logic                     result_valid;
    logic [ADDR_W-1:0]        sampled_index;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [LEN_W-1:0]         cfg_data;

    // Predictor state: the cumulative table, the running sum, the fill position and the
    // search length as the block should hold them after every accepted word.
    logic [VAL_W-1:0]         cdf_tab [TABLE_DEPTH];
    logic [VAL_W-1:0]         cdf_sum;
    logic [POS_W-1:0]         cdf_fill;
    logic [LEN_W-1:0]         search_len;

    // Indexes still owed by the block, oldest first.
    logic [ADDR_W-1:0]        index_q [$];

    int                       err_count;
    int                       word_count;
    // When set, the sender pushes words back to back with no gaps.
    bit                       no_idle;

    inverse_cdf_sampler_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .restart       (restart),
        .prob_entry    (prob_entry),
        .uniform_draw  (uniform_draw),
        .result_valid  (result_valid),
        .sampled_index (sampled_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net: a hung handshake or a missing result ends the run here.
    initial
    begin
        #(20 * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Effective search count: the length register clamped to 1..TABLE_DEPTH and then to the
    // number of entries written since the last restart.
    function automatic int searchable_count();
        int n;
        n = int'(search_len);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > TABLE_DEPTH)
        begin
            n = TABLE_DEPTH;
        end
        if (n > int'(cdf_fill))
        begin
            n = int'(cdf_fill);
        end
        return n;
    endfunction

    // Smallest searched index whose cumulative value is strictly above the draw, clamped to
    // the last searched index; an empty table gives index zero.
    function automatic logic [ADDR_W-1:0] pick_index(input logic [FRACTION_BITS-1:0] draw);
        int n;
        int lo;
        int hi;
        int mid;
        n  = searchable_count();
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (cdf_tab[mid] > {1'b0, draw})
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        if (n == 0)
        begin
            return '0;
        end
        else if (lo >= n)
        begin
            return ADDR_W'(n - 1);
        end
        return ADDR_W'(lo);
    endfunction

    // Adds one probability to the running sum, saturating at one, and stores the sum unless
    // the table is already full. A restart clears the sum and the fill position first.
    task automatic load_entry(input logic rs, input logic [VAL_W-1:0] pr);
        logic [VAL_W:0] sum;
        if (rs)
        begin
            cdf_sum  = '0;
            cdf_fill = '0;
        end
        sum = {1'b0, cdf_sum} + {1'b0, pr};
        if (sum > {1'b0, ONE_VALUE})
        begin
            sum = {1'b0, ONE_VALUE};
        end
        cdf_sum = sum[VAL_W-1:0];
        if (cdf_fill < DEPTH_COUNT)
        begin
            cdf_tab[cdf_fill] = cdf_sum;
            cdf_fill++;
        end
    endtask

    // Mostly short gaps, a few long ones, none at all during a no-idle stretch.
    function automatic int next_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // Sends one word. It is entered just after a falling edge, holds start until the word is
    // taken at a rising edge with busy low, updates the predictor there, and returns just
    // after a later falling edge. Start is only lowered when a gap follows, so back-to-back
    // words never see start dropped and raised in the same time step.
    task automatic send_word(input logic m, input logic rs,
                             input logic [VAL_W-1:0] pr,
                             input logic [FRACTION_BITS-1:0] dr);
        int gap;
        start        <= 1'b1;
        mode         <= m;
        restart      <= rs;
        prob_entry   <= pr;
        uniform_draw <= dr;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (m == 1'b0)
        begin
            load_entry(rs, pr);
        end
        else
        begin
            index_q.push_back(pick_index(dr));
        end
        word_count++;
        @(negedge clk);
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Lowers start and waits until every owed index has come back and the block is quiet.
    // Loads leave nothing to wait for, so a few extra cycles cover one still in flight.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (index_q.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the length register through its own channel; only called with the block idle.
    task automatic write_length(input logic [LEN_W-1:0] len);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        search_len = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Probability for one of `size` entries: mostly small enough that the sum climbs
    // gradually, with zeros, exact ones and full-width values mixed in.
    function automatic logic [VAL_W-1:0] rand_prob(input int size);
        int hi;
        hi = (2 * int'(ONE_VALUE)) / (size > 0 ? size : 1);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_VALUE;
            2: return VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
            3: return VAL_W'($urandom_range(0, int'(ONE_VALUE) - 1));
            default: return VAL_W'($urandom_range(0, hi));
        endcase
    endfunction

    // Draw that is either fully random or sits on or next to a stored cumulative value, where
    // an off-by-one in the search shows up.
    function automatic logic [FRACTION_BITS-1:0] rand_draw();
        int idx;
        int v;
        if (cdf_fill != 0 && $urandom_range(0, 1) == 1)
        begin
            idx = $urandom_range(0, int'(cdf_fill) - 1);
            v   = int'(cdf_tab[idx]) + int'($urandom_range(0, 2)) - 1;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > int'(ONE_VALUE) - 1)
            begin
                v = int'(ONE_VALUE) - 1;
            end
            return FRACTION_BITS'(v);
        end
        return FRACTION_BITS'($urandom_range(0, int'(ONE_VALUE) - 1));
    endfunction

    // A well-formed sequence: restart, `size` loads, then `draws` samples.
    task automatic load_and_sample(input int size, input int draws);
        send_word(1'b0, 1'b1, rand_prob(size), FRACTION_BITS'($urandom));
        for (int i = 1; i < size; i++)
        begin
            send_word(1'b0, 1'b0, rand_prob(size), FRACTION_BITS'($urandom));
        end
        for (int i = 0; i < draws; i++)
        begin
            send_word(1'b1, 1'($urandom), VAL_W'($urandom), rand_draw());
        end
    endtask

    // Hand-picked words: empty table, saturation, full-width probabilities, draw extremes,
    // appending without restart, a restart flag on a sample, and the clamp when no entry
    // exceeds the draw.
    task automatic test_directed();
        // Nothing written since reset, so every sample gives index zero.
        send_word(1'b1, 1'b0, '0, '0);
        send_word(1'b1, 1'b1, '1, '1);
        // Zero first, then an all-ones probability that must saturate at one.
        send_word(1'b0, 1'b1, '0, '0);
        send_word(1'b0, 1'b0, '1, '1);
        send_word(1'b0, 1'b0, ONE_VALUE, '0);
        send_word(1'b1, 1'b0, '0, '0);
        send_word(1'b1, 1'b0, '0, '1);
        // Two halves that add to exactly one.
        send_word(1'b0, 1'b1, VAL_W'(32768), '0);
        send_word(1'b0, 1'b0, VAL_W'(32768), '0);
        send_word(1'b1, 1'b0, '0, FRACTION_BITS'(32767));
        send_word(1'b1, 1'b0, '0, FRACTION_BITS'(32768));
        send_word(1'b1, 1'b0, '0, '1);
        // A single tiny entry: a draw at or above it is clamped to the last index.
        send_word(1'b0, 1'b1, VAL_W'(1), '0);
        send_word(1'b1, 1'b0, '0, '0);
        send_word(1'b1, 1'b0, '0, FRACTION_BITS'(1));
        // Appending without restart extends the current table.
        send_word(1'b0, 1'b0, VAL_W'(16'h5555), '0);
        send_word(1'b0, 1'b0, VAL_W'(16'hAAAA), '0);
        send_word(1'b1, 1'b0, '0, FRACTION_BITS'(16'h5555));
        send_word(1'b1, 1'b0, '0, FRACTION_BITS'(16'h5556));
        // A restart flag on a sample must leave the table alone.
        send_word(1'b1, 1'b1, '0, FRACTION_BITS'(2));
        send_word(1'b1, 1'b0, '0, FRACTION_BITS'(2));
        // A table holding only zero.
        send_word(1'b0, 1'b1, '0, '1);
        send_word(1'b1, 1'b0, '0, '0);
        drain_results();
    endtask

    // Length register at its extremes and beyond: zero acts as one, above the depth acts as
    // the depth, and a short register hides written entries from the search.
    task automatic test_length_extremes();
        logic [LEN_W-1:0] lens [8];
        lens = '{LEN_W'(1), LEN_W'(2), LEN_W'(0), LEN_W'(511),
                 LEN_W'(257), LEN_W'(256), LEN_W'(300), LEN_W'(128)};
        foreach (lens[i])
        begin
            write_length(lens[i]);
            load_and_sample($urandom_range(1, 40), 8);
        end
    endtask

    // Fills the table past its depth: the extra loads are dropped and the search still
    // covers every entry.
    task automatic test_table_full();
        write_length(LEN_W'(256));
        no_idle = 1'b1;
        load_and_sample(TABLE_DEPTH + 4, 12);
        no_idle = 1'b0;
        write_length(LEN_W'(511));
        for (int i = 0; i < 8; i++)
        begin
            send_word(1'b1, 1'b0, '0, rand_draw());
        end
        write_length(LEN_W'($urandom_range(1, 255)));
        for (int i = 0; i < 8; i++)
        begin
            send_word(1'b1, 1'b0, '0, rand_draw());
        end
    endtask

    // Mostly well-formed restart/load/sample sequences with random content, the rest loose
    // words in any mode, with length rewrites and no-idle stretches in between.
    task automatic test_random();
        int first_count;
        int size;
        int r;
        first_count = word_count;
        while (word_count - first_count < WORD_GOAL)
        begin
            no_idle = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 3) == 0)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    write_length(LEN_W'(0));
                end
                else if (r == 1)
                begin
                    write_length(LEN_W'(511));
                end
                else if (r == 2)
                begin
                    write_length(LEN_W'(256));
                end
                else if (r < 6)
                begin
                    write_length(LEN_W'($urandom_range(1, 16)));
                end
                else
                begin
                    write_length(LEN_W'($urandom_range(0, 511)));
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                begin
                    send_word(1'($urandom), 1'($urandom), VAL_W'($urandom),
                              FRACTION_BITS'($urandom));
                end
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    size = $urandom_range(1, 16);
                end
                else if (r < 97)
                begin
                    size = $urandom_range(17, 64);
                end
                else
                begin
                    size = $urandom_range(200, 300);
                end
                load_and_sample(size, $urandom_range(1, 12));
            end
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // Every strobed index is taken at the rising edge that ends its cycle and checked
    // against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (index_q.size() == 0)
            begin
                report_error($sformatf("unexpected result, sampled_index=%0d", sampled_index));
            end
            else if (sampled_index !== index_q[0])
            begin
                report_error($sformatf("sampled_index=%0d, expected %0d",
                                       sampled_index, index_q[0]));
                void'(index_q.pop_front());
            end
            else
            begin
                void'(index_q.pop_front());
            end
        end
    end

    initial
    begin
        // All inputs known from time zero; reset is held low first and released on a falling edge.
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = 1'b0;
        restart      = 1'b0;
        prob_entry   = '0;
        uniform_draw = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        err_count    = 0;
        word_count   = 0;
        no_idle      = 1'b0;
        cdf_sum      = '0;
        cdf_fill     = '0;
        search_len   = LEN_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_length_extremes();
        test_table_full();
        test_random();

        // Nothing owed any more; give the block a few cycles for a stray strobe.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
